>>> hdl/longest_run_sum_divisible_unit_defines.svh
// Assertion macros for the checker file of the longest run unit.
`ifndef LONGEST_RUN_SUM_DIVISIBLE_UNIT_DEFINES_SVH
`define LONGEST_RUN_SUM_DIVISIBLE_UNIT_DEFINES_SVH

// Check on every clock edge outside reset.
`define LRSD_ASSERT(name, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) expr) \
        else $error(msg);

// Check on every clock edge, reset included.
`define LRSD_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge i_clk) expr) \
        else $error(msg);

`endif

>>> hdl/lrsd_pkg.sv
// Shared widths, types and constants of the longest run unit.
package lrsd_pkg;

    localparam int VALUE_W = 32;
    localparam int LEN_W   = 21;
    localparam int MOD_W   = 7;
    localparam int SUM_W   = VALUE_W + 1;
    localparam int CNT_W   = $clog2(SUM_W + 1);
    // Queue depth, a power of two
    localparam int Q_DEPTH = 2;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [MOD_W-1:0]   t_mod;
    typedef logic [SUM_W-1:0]   t_sum;
    typedef logic [CNT_W-1:0]   t_cnt;

    localparam t_mod MOD_RESET = 7'd7;

    typedef struct packed {
        t_value value;
        logic   last;
    } t_item;

endpackage

>>> hdl/lrsd_if.sv
// Channel interfaces: input items, result items and modulus writes.
interface lrsd_in_if;
    logic            valid;
    logic            ready;
    lrsd_pkg::t_value value;
    logic            last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface lrsd_out_if;
    logic          valid;
    logic          ready;
    lrsd_pkg::t_len longest_length;
    logic          overflow;

    modport source (output valid, output longest_length, output overflow, input ready);
    modport sink   (input valid, input longest_length, input overflow, output ready);
endinterface

interface lrsd_cfg_if;
    logic          valid;
    logic          ready;
    lrsd_pkg::t_mod data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/lrsd_front.sv
// Front end: accepts input beats into a short queue for the back end.
module lrsd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lrsd_in_if.sink            i_item,
    output logic               o_q_valid,
    output lrsd_pkg::t_item    o_q_item,
    input  logic               i_q_pop
);

    localparam int PTR_W = (lrsd_pkg::Q_DEPTH > 1) ? $clog2(lrsd_pkg::Q_DEPTH) : 1;
    localparam int QC_W  = $clog2(lrsd_pkg::Q_DEPTH + 1);

    lrsd_pkg::t_item   r_q [lrsd_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [QC_W-1:0]   r_cnt;
    logic              push;
    logic              pop;

    assign i_item.ready = (r_cnt != QC_W'(lrsd_pkg::Q_DEPTH));
    assign push         = i_item.valid && i_item.ready;
    assign pop          = i_q_pop && o_q_valid;
    assign o_q_valid    = (r_cnt != '0);
    assign o_q_item     = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{value: i_item.value, last: i_item.last};
        end
    end

endmodule

>>> hdl/lrsd_rem.sv
// Bit-serial remainder unit: reduces a 33-bit sum modulo the modulus.
module lrsd_rem #(
    parameter int MAX_MODULUS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  lrsd_pkg::t_sum                       i_sum,
    input  logic [$clog2(MAX_MODULUS+1)-1:0]     i_mod,
    output logic                                 o_done,
    output logic [$clog2(MAX_MODULUS)-1:0]       o_rem
);

    localparam int MW = $clog2(MAX_MODULUS + 1);
    localparam int RW = $clog2(MAX_MODULUS);
    localparam int AW = RW + 1;

    logic                r_busy;
    logic                r_done;
    lrsd_pkg::t_cnt      r_cnt;
    lrsd_pkg::t_sum      r_sh;
    logic [RW-1:0]       r_acc;
    logic [MW-1:0]       r_m;
    logic [AW-1:0]       acc2;
    logic [AW-1:0]       diff;
    logic                ge;
    logic [RW-1:0]       n_acc;

    // One quotient bit a cycle: shift in the next sum bit, subtract when it fits
    always_comb begin
        acc2  = {r_acc, r_sh[lrsd_pkg::SUM_W-1]};
        ge    = (acc2 >= AW'(r_m));
        diff  = acc2 - AW'(r_m);
        n_acc = ge ? diff[RW-1:0] : acc2[RW-1:0];
    end

    assign o_done = r_done;
    assign o_rem  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= lrsd_pkg::t_cnt'(lrsd_pkg::SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == lrsd_pkg::t_cnt'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_sh  <= i_sum;
            r_m   <= i_mod;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_sh  <= {r_sh[lrsd_pkg::SUM_W-2:0], 1'b0};
        end
    end

endmodule

>>> hdl/lrsd_back.sv
// Back end: remainder update, first-position table, best length and result register.
module lrsd_back #(
    parameter int MAX_MODULUS   = 64,
    parameter int POSITION_BITS = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lrsd_cfg_if.sink         i_cfg,
    input  logic             i_q_valid,
    input  lrsd_pkg::t_item  i_q_item,
    output logic             o_q_pop,
    lrsd_out_if.source       o_res
);

    localparam int MW = $clog2(MAX_MODULUS + 1);
    localparam int RW = $clog2(MAX_MODULUS);
    localparam int PB = POSITION_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0]             r_st, n_st;
    lrsd_pkg::t_mod         r_mod;
    logic [RW-1:0]          r_rr, n_rr;
    logic [PB-1:0]          r_pos, n_pos;
    logic [MAX_MODULUS-1:0] r_seen, n_seen;
    logic [PB-1:0]          r_best, n_best;
    logic                   r_ovf, n_ovf;
    logic                   r_last, n_last;
    logic                   r_skip, n_skip;
    logic                   r_ov, n_ov;
    lrsd_pkg::t_len         r_len, n_len;
    logic                   r_oflow, n_oflow;
    logic [PB-1:0]          mem [MAX_MODULUS];
    logic [PB-1:0]          r_rd;
    logic                   mem_we;
    logic [MW-1:0]          eff_mod;
    logic                   rem_start;
    logic                   rem_done;
    logic [RW-1:0]          rem_val;
    lrsd_pkg::t_sum         sum;
    logic [PB-1:0]          here;
    logic [PB-1:0]          first;
    logic [PB-1:0]          span;
    logic                   out_full;

    lrsd_rem #(
        .MAX_MODULUS (MAX_MODULUS)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_sum   (sum),
        .i_mod   (eff_mod),
        .o_done  (rem_done),
        .o_rem   (rem_val)
    );

    assign i_cfg.ready          = 1'b1;
    assign o_res.valid          = r_ov;
    assign o_res.longest_length = r_len;
    assign o_res.overflow       = r_oflow;

    // Zero acts as one, anything above the table size as the table size
    always_comb begin
        if (r_mod == '0) begin
            eff_mod = MW'(1);
        end else if (32'(r_mod) > MAX_MODULUS) begin
            eff_mod = MW'(MAX_MODULUS);
        end else begin
            eff_mod = MW'(r_mod);
        end
    end

    assign sum      = {1'b0, i_q_item.value} + lrsd_pkg::t_sum'(r_rr);
    assign here     = r_pos + 1'b1;
    // Remainder zero counts as seen before the first element
    assign first    = (rem_val == '0) ? '0 : r_rd;
    assign span     = here - first;
    assign out_full = r_ov && !o_res.ready;

    always_comb begin
        n_st      = r_st;
        n_rr      = r_rr;
        n_pos     = r_pos;
        n_seen    = r_seen;
        n_best    = r_best;
        n_ovf     = r_ovf;
        n_last    = r_last;
        n_skip    = r_skip;
        n_ov      = r_ov;
        n_len     = r_len;
        n_oflow   = r_oflow;
        o_q_pop   = 1'b0;
        rem_start = 1'b0;
        mem_we    = 1'b0;

        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        case (r_st)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_last  = i_q_item.last;
                    // Saturated position: drop the element, keep the flag
                    if (r_ovf || (r_pos == '1)) begin
                        n_ovf  = 1'b1;
                        n_skip = 1'b1;
                        n_st   = S_UPD;
                    end else begin
                        n_skip    = 1'b0;
                        rem_start = 1'b1;
                        n_st      = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (rem_done) begin
                    n_st = S_READ;
                end
            end
            S_READ: begin
                n_st = S_UPD;
            end
            S_UPD: begin
                // Hold a final beat until the result register is free
                if (!r_last || !out_full) begin
                    if (!r_skip) begin
                        n_rr  = rem_val;
                        n_pos = here;
                        if (r_seen[rem_val]) begin
                            if (span > r_best) begin
                                n_best = span;
                            end
                        end else begin
                            n_seen[rem_val] = 1'b1;
                            mem_we          = 1'b1;
                        end
                    end
                    if (r_last) begin
                        n_ov    = 1'b1;
                        n_len   = lrsd_pkg::t_len'(n_best);
                        n_oflow = r_ovf;
                        n_rr    = '0;
                        n_pos   = '0;
                        n_seen  = MAX_MODULUS'(1);
                        n_best  = '0;
                        n_ovf   = 1'b0;
                    end
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_mod   <= lrsd_pkg::MOD_RESET;
            r_rr    <= '0;
            r_pos   <= '0;
            r_seen  <= MAX_MODULUS'(1);
            r_best  <= '0;
            r_ovf   <= 1'b0;
            r_last  <= 1'b0;
            r_skip  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_rr   <= n_rr;
            r_pos  <= n_pos;
            r_seen <= n_seen;
            r_best <= n_best;
            r_ovf  <= n_ovf;
            r_last <= n_last;
            r_skip <= n_skip;
            r_ov   <= n_ov;
            if (i_cfg.valid && i_cfg.ready) begin
                r_mod <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_oflow <= n_oflow;
    end

    // First-position table, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[rem_val] <= here;
        end
        if (r_st == S_READ) begin
            r_rd <= mem[rem_val];
        end
    end

endmodule

>>> hdl/longest_run_sum_divisible_unit.sv
// Top level of the longest divisible-sum run unit.
//
//  channel   modport   direction  payload
//  i_item    sink      in         value[31:0], last
//  o_res     source    out        longest_length[20:0], overflow
//  i_cfg     sink      in         data[6:0] (modulus)
//
// An item passes through the back end in order: dequeue, 33 steps of the
// bit-serial remainder unit over the 33-bit sum, registering its done flag,
// a table read and an update; no new item is taken until it is through.
// An item after the position count saturates goes from dequeue to the update.
// Synchronous active-low reset clears all sequence state at once; no sweep.
// The input queue accepts until full as the back end works or a result waits;
// a final item holds in the update step until the result register is free.
module longest_run_sum_divisible_unit #(
    parameter int MAX_MODULUS   = 64,
    parameter int POSITION_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrsd_in_if.sink     i_item,
    lrsd_cfg_if.sink    i_cfg,
    lrsd_out_if.source  o_res
);

    logic            q_valid;
    lrsd_pkg::t_item q_item;
    logic            q_pop;

    lrsd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    lrsd_back #(
        .MAX_MODULUS   (MAX_MODULUS),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

>>> hdl/lrsd_checker.sv
// Port-level checks of the longest run unit and their bind to the top level.
`include "longest_run_sum_divisible_unit_defines.svh"

module lrsd_checker #(
    parameter int POSITION_BITS = 20
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input lrsd_pkg::t_len i_out_len,
    input logic           i_out_ovf
);

    localparam longint unsigned LEN_BOUND = (64'd1 << POSITION_BITS) - 64'd1;

    `LRSD_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (!i_out_valid && i_in_ready), "reset did not clear the channels")
    `LRSD_ASSERT(a_out_holds, (i_out_valid && !i_out_ready) |=> i_out_valid, "result beat dropped while stalled")
    `LRSD_ASSERT(a_out_stable, (i_out_valid && !i_out_ready) |=> ($stable(i_out_len) && $stable(i_out_ovf)), "result payload changed while stalled")
    `LRSD_ASSERT(a_len_bound, i_out_valid |-> (64'(i_out_len) <= LEN_BOUND), "run length beyond position range")

endmodule

bind longest_run_sum_divisible_unit lrsd_checker #(
    .POSITION_BITS (POSITION_BITS)
) u_lrsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_len   (o_res.longest_length),
    .i_out_ovf   (o_res.overflow)
);
